[rtl/tsl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared codes, widths, reset values and types of the turn stalk interpreter.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int STALK_W   = 3;
    localparam int STATUS_W  = 3;
    localparam int DIR_W     = 2;
    localparam int HOLD_W    = 8;
    localparam int LOCK_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [STALK_W-1:0] STALK_NONE        = 3'd0;
    localparam logic [STALK_W-1:0] STALK_LEFT_LIGHT  = 3'd1;
    localparam logic [STALK_W-1:0] STALK_RIGHT_LIGHT = 3'd2;
    localparam logic [STALK_W-1:0] STALK_LEFT_FIRM   = 3'd3;
    localparam logic [STALK_W-1:0] STALK_RIGHT_FIRM  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_KEEPING   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PROPOSE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXECUTION = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HOLD      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CANCEL    = 3'd4;

    localparam logic [DIR_W-1:0] DIR_NONE  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_BAD   = 2'd3;

    localparam logic [HOLD_W-1:0] RST_CANCEL_HOLD_LIMIT       = 8'd40;
    localparam logic [HOLD_W-1:0] RST_INTERACTIVE_HOLD_PRESET = 8'd35;
    localparam logic [LOCK_W-1:0] RST_RETRIGGER_LIMIT         = 4'd11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANCEL_HOLD_LIMIT       = 2'd0,
        CFG_INTERACTIVE_HOLD_PRESET = 2'd1,
        CFG_RETRIGGER_LIMIT         = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [HOLD_W-1:0] cancel_hold_limit;
        logic [HOLD_W-1:0] interactive_hold_preset;
        logic [LOCK_W-1:0] retrigger_limit;
    } t_cfg;

    typedef struct packed {
        logic [STALK_W-1:0]  stalk_position;
        logic [STATUS_W-1:0] change_status;
        logic [DIR_W-1:0]    request_direction;
        logic                split_present;
        logic                source_interactive;
    } t_item;

    typedef struct packed {
        logic [DIR_W-1:0] latched_command;
        logic             cancel_active;
    } t_result;

    typedef struct packed {
        logic [STALK_W-1:0] previous_stalk;
        logic [DIR_W-1:0]   command_reg;
        logic [LOCK_W-1:0]  lockout_count;
        logic [HOLD_W-1:0]  hold_count;
    } t_state;

endpackage
`default_nettype wire

[rtl/tsl_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_in_if
// Input channel: one frame of stalk, status and request fields.
// ----------------------------------------------------------------------------
interface tsl_in_if
    import tsl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STALK_W-1:0]  stalk_position;
    logic [STATUS_W-1:0] change_status;
    logic [DIR_W-1:0]    request_direction;
    logic                split_present;
    logic                source_interactive;

    modport source (
        output valid, stalk_position, change_status, request_direction,
               split_present, source_interactive,
        input  ready
    );
    modport sink (
        input  valid, stalk_position, change_status, request_direction,
               split_present, source_interactive,
        output ready
    );
endinterface
`default_nettype wire

[rtl/tsl_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_out_if
// Result channel: latched command and cancel flag of one frame.
// ----------------------------------------------------------------------------
interface tsl_out_if
    import tsl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] latched_command;
    logic             cancel_active;

    modport source (
        output valid, latched_command, cancel_active,
        input  ready
    );
    modport sink (
        input  valid, latched_command, cancel_active,
        output ready
    );
endinterface
`default_nettype wire

[rtl/tsl_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_step
// Next-state and result logic for one frame: latch, lockout, cancel, hold.
// ----------------------------------------------------------------------------
module tsl_step
    import tsl_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    logic              cancel_ok;
    logic              prev_free;
    logic              may_latch;
    logic              cancel_left;
    logic              cancel_right;
    logic              push_right;
    logic              push_left;
    logic [LOCK_W:0]   lock_inc;
    logic [LOCK_W-1:0] lock_sat;
    logic [DIR_W-1:0]  cmd_latched;
    logic [HOLD_W-1:0] hold_start;

    always_comb begin
        cancel_ok = (i_item.change_status == ST_PROPOSE)
                 || (i_item.change_status == ST_EXECUTION)
                 || (i_item.change_status == ST_HOLD)
                 || (i_item.change_status == ST_CANCEL)
                 || i_item.split_present;
        prev_free = (i_state.previous_stalk == STALK_NONE)
                 || (i_state.previous_stalk == STALK_LEFT_LIGHT)
                 || (i_state.previous_stalk == STALK_RIGHT_LIGHT);
        may_latch = (i_item.change_status == ST_KEEPING)
                 && (i_item.request_direction == DIR_NONE)
                 && prev_free
                 && (i_state.lockout_count >= i_cfg.retrigger_limit);
        push_right = (i_item.stalk_position == STALK_RIGHT_LIGHT)
                  || (i_item.stalk_position == STALK_RIGHT_FIRM);
        push_left  = (i_item.stalk_position == STALK_LEFT_LIGHT)
                  || (i_item.stalk_position == STALK_LEFT_FIRM);
        cancel_left  = cancel_ok && push_right
                    && ((i_item.request_direction == DIR_LEFT)
                        || (i_state.command_reg == DIR_LEFT));
        cancel_right = cancel_ok && push_left
                    && ((i_item.request_direction == DIR_RIGHT)
                        || (i_state.command_reg == DIR_RIGHT));

        // latch
        cmd_latched = i_state.command_reg;
        if (may_latch && (i_item.stalk_position == STALK_LEFT_FIRM)) begin
            cmd_latched = DIR_LEFT;
        end else if (may_latch && (i_item.stalk_position == STALK_RIGHT_FIRM)) begin
            cmd_latched = DIR_RIGHT;
        end

        // lockout saturating advance
        lock_inc = {1'b0, i_state.lockout_count} + {{LOCK_W{1'b0}}, 1'b1};
        if (lock_inc > {1'b0, i_cfg.retrigger_limit}) begin
            lock_sat = i_cfg.retrigger_limit;
        end else begin
            lock_sat = lock_inc[LOCK_W-1:0];
        end

        // cancel wins over latch
        hold_start = i_state.hold_count;
        o_state.command_reg   = cmd_latched;
        o_state.lockout_count = lock_sat;
        if (cancel_left || cancel_right) begin
            hold_start = i_item.source_interactive ? i_cfg.interactive_hold_preset
                                                   : '0;
            o_state.command_reg   = DIR_NONE;
            o_state.lockout_count = '0;
        end

        o_state.previous_stalk = i_item.stalk_position;

        // hold advance
        if (hold_start < i_cfg.cancel_hold_limit) begin
            o_state.hold_count     = hold_start + 8'd1;
            o_result.cancel_active = 1'b1;
        end else begin
            o_state.hold_count     = i_cfg.cancel_hold_limit;
            o_result.cancel_active = 1'b0;
        end

        o_result.latched_command = o_state.command_reg;
    end

endmodule
`default_nettype wire

[rtl/turn_stalk_lane_change_interpreter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// turn_stalk_lane_change_interpreter
// Interprets turn-stalk pushes per planning frame into a latched lane-change
// command and a timed cancel flag.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  i_item    | in  | valid/ready   | stalk, status, request, split, interactive
//  o_result  | out | valid/ready   | latched_command, cancel_active
//  i_cfg_*   | in  | write enable  | index 0..2, 8-bit data
//
//  One transaction per cycle sustained while results are taken; the input
//  register feeds the frame logic into the result register and the frame state.
//  Reset clears both stage valids and sets frame state and config registers to defaults.
//  A stalled result holds; the input register still takes one more
//  transaction, after which ready drops until the result is taken.
// ----------------------------------------------------------------------------
module turn_stalk_lane_change_interpreter
    import tsl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tsl_in_if.sink                     i_item,
    tsl_out_if.source                  o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cfg    r_cfg;

    t_state  n_state;
    t_result n_out;
    logic    out_free;
    logic    in_ready;
    logic    advance;

    assign out_free = !r_out_valid || o_result.ready;
    assign in_ready = !r_in_valid || out_free;
    assign advance  = r_in_valid && out_free;

    tsl_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.previous_stalk <= STALK_NONE;
            r_state.command_reg    <= DIR_NONE;
            r_state.lockout_count  <= RST_RETRIGGER_LIMIT;
            r_state.hold_count     <= RST_CANCEL_HOLD_LIMIT;
            r_cfg.cancel_hold_limit       <= RST_CANCEL_HOLD_LIMIT;
            r_cfg.interactive_hold_preset <= RST_INTERACTIVE_HOLD_PRESET;
            r_cfg.retrigger_limit         <= RST_RETRIGGER_LIMIT;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CANCEL_HOLD_LIMIT: begin
                        r_cfg.cancel_hold_limit <= i_cfg_data[HOLD_W-1:0];
                    end
                    CFG_INTERACTIVE_HOLD_PRESET: begin
                        r_cfg.interactive_hold_preset <= i_cfg_data[HOLD_W-1:0];
                    end
                    CFG_RETRIGGER_LIMIT: begin
                        r_cfg.retrigger_limit <= i_cfg_data[LOCK_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_in.stalk_position     <= i_item.stalk_position;
            r_in.change_status      <= i_item.change_status;
            r_in.request_direction  <= i_item.request_direction;
            r_in.split_present      <= i_item.split_present;
            r_in.source_interactive <= i_item.source_interactive;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign i_item.ready             = in_ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.latched_command = r_out.latched_command;
    assign o_result.cancel_active   = r_out.cancel_active;

endmodule
`default_nettype wire

[rtl/tsl_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_checker
// Port-level checks of the turn stalk interpreter, bound to the top level.
// ----------------------------------------------------------------------------
module tsl_checker
    import tsl_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [DIR_W-1:0] out_command,
    input wire logic             out_cancel
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_command) && $stable(out_cancel))
        else $error("stalled result payload changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    a_command_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_command != DIR_BAD)
        else $error("latched command carries an unnamed code");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !out_valid && in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind turn_stalk_lane_change_interpreter tsl_checker u_tsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_ready    (i_item.ready),
    .out_valid   (o_result.valid),
    .out_ready   (o_result.ready),
    .out_command (o_result.latched_command),
    .out_cancel  (o_result.cancel_active)
);
`default_nettype wire

[tb/turn_stalk_lane_change_interpreter_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// turn_stalk_lane_change_interpreter_tb
// Self-checking bench for the turn stalk interpreter. A burst driver feeds
// frames from a pending queue, a frame predictor computes the command and
// cancel flag of every accepted frame, and a stalling monitor compares each
// result transaction in order. Directed frames come first, then random
// frames, mostly maneuver-shaped, under several limit settings and extremes.
// ----------------------------------------------------------------------------
module turn_stalk_lane_change_interpreter_tb;
    import tsl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_FRAMES = 135;

    localparam logic [STALK_W-1:0]   STALK_SPARE_LO = 3'd5;
    localparam logic [STALK_W-1:0]   STALK_SPARE_MID = 3'd6;
    localparam logic [STALK_W-1:0]   STALK_SPARE_HI = 3'd7;
    localparam logic [STATUS_W-1:0]  ST_OTHER = 3'd5;
    localparam logic [STATUS_W-1:0]  ST_SPARE_MID = 3'd6;
    localparam logic [STATUS_W-1:0]  ST_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_item drv_item = '0;
    logic  drv_valid = 1'b0;
    logic  mon_ready = 1'b0;

    tsl_in_if  item_if ();
    tsl_out_if result_if ();

    assign item_if.valid              = drv_valid;
    assign item_if.stalk_position     = drv_item.stalk_position;
    assign item_if.change_status      = drv_item.change_status;
    assign item_if.request_direction  = drv_item.request_direction;
    assign item_if.split_present      = drv_item.split_present;
    assign item_if.source_interactive = drv_item.source_interactive;
    assign result_if.ready            = mon_ready;

    turn_stalk_lane_change_interpreter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_item   pending_frames[$];
    t_result expected_frames[$];

    logic [HOLD_W-1:0]  hold_limit_q = RST_CANCEL_HOLD_LIMIT;
    logic [HOLD_W-1:0]  hold_preset_q = RST_INTERACTIVE_HOLD_PRESET;
    logic [LOCK_W-1:0]  retrigger_q = RST_RETRIGGER_LIMIT;

    logic [STALK_W-1:0] prev_stalk_q = STALK_NONE;
    logic [DIR_W-1:0]   command_q = DIR_NONE;
    logic [LOCK_W-1:0]  lockout_q = RST_RETRIGGER_LIMIT;
    logic [HOLD_W-1:0]  hold_q = RST_CANCEL_HOLD_LIMIT;

    int error_count = 0;
    int frames_queued = 0;
    int frames_sent = 0;
    int frames_checked = 0;
    int command_frames = 0;
    int cancel_frames = 0;
    int settings_used = 1;
    int burst_left = 0;
    int gap_left = 0;
    int ready_mode = 0;
    int ready_left = 0;
    int ready_phase = 0;
    int quiet_cycles = 0;

    function automatic t_result predict_frame(input t_item it);
        logic            cancel_ok;
        logic            prev_free;
        logic            may_latch;
        logic            cut_left;
        logic            cut_right;
        logic [LOCK_W:0] lock_next;
        t_result         res;
        cancel_ok = it.split_present || it.change_status == ST_PROPOSE ||
                    it.change_status == ST_EXECUTION || it.change_status == ST_HOLD ||
                    it.change_status == ST_CANCEL;
        prev_free = prev_stalk_q == STALK_NONE || prev_stalk_q == STALK_LEFT_LIGHT ||
                    prev_stalk_q == STALK_RIGHT_LIGHT;
        may_latch = it.change_status == ST_KEEPING && it.request_direction == DIR_NONE &&
                    prev_free && lockout_q >= retrigger_q;
        cut_left  = cancel_ok &&
                    (it.request_direction == DIR_LEFT || command_q == DIR_LEFT) &&
                    (it.stalk_position == STALK_RIGHT_LIGHT ||
                     it.stalk_position == STALK_RIGHT_FIRM);
        cut_right = cancel_ok &&
                    (it.request_direction == DIR_RIGHT || command_q == DIR_RIGHT) &&
                    (it.stalk_position == STALK_LEFT_LIGHT ||
                     it.stalk_position == STALK_LEFT_FIRM);

        if (may_latch && it.stalk_position == STALK_LEFT_FIRM) begin
            command_q = DIR_LEFT;
        end else if (may_latch && it.stalk_position == STALK_RIGHT_FIRM) begin
            command_q = DIR_RIGHT;
        end

        lock_next = {1'b0, lockout_q} + 1'b1;
        lockout_q = (lock_next > {1'b0, retrigger_q}) ? retrigger_q : lock_next[LOCK_W-1:0];

        if (cut_left || cut_right) begin
            hold_q    = it.source_interactive ? hold_preset_q : '0;
            command_q = DIR_NONE;
            lockout_q = '0;
        end

        prev_stalk_q = it.stalk_position;

        if (hold_q < hold_limit_q) begin
            res.cancel_active = 1'b1;
            hold_q = hold_q + 1'b1;
        end else begin
            res.cancel_active = 1'b0;
            hold_q = hold_limit_q;
        end
        res.latched_command = command_q;
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("turn_stalk_lane_change_interpreter_tb: MISMATCH %s", msg);
        error_count++;
    endtask

    task automatic queue_frame(input logic [STALK_W-1:0] stalk,
                               input logic [STATUS_W-1:0] status,
                               input logic [DIR_W-1:0] req,
                               input logic split, input logic interactive);
        t_item it;
        it.stalk_position     = stalk;
        it.change_status      = status;
        it.request_direction  = req;
        it.split_present      = split;
        it.source_interactive = interactive;
        pending_frames.push_back(it);
        frames_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CANCEL_HOLD_LIMIT:       hold_limit_q = data;
            CFG_INTERACTIVE_HOLD_PRESET: hold_preset_q = data;
            CFG_RETRIGGER_LIMIT:         retrigger_q = data[LOCK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_limits(input logic [HOLD_W-1:0] hold_limit,
                                  input logic [HOLD_W-1:0] preset,
                                  input logic [CFG_DATA_W-1:0] retrigger);
        write_reg(CFG_CANCEL_HOLD_LIMIT, hold_limit);
        write_reg(CFG_INTERACTIVE_HOLD_PRESET, preset);
        write_reg(CFG_RETRIGGER_LIMIT, retrigger);
        settings_used++;
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0 || drv_valid || expected_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_maneuver();
        logic [DIR_W-1:0]    dir;
        logic [DIR_W-1:0]    opp_req;
        logic [STALK_W-1:0]  firm;
        logic [STALK_W-1:0]  light;
        logic [STALK_W-1:0]  opp;
        logic [STATUS_W-1:0] status;
        logic                interactive;
        logic                split;
        dir         = ($urandom_range(0, 1) == 1) ? DIR_LEFT : DIR_RIGHT;
        firm        = (dir == DIR_LEFT) ? STALK_LEFT_FIRM : STALK_RIGHT_FIRM;
        light       = (dir == DIR_LEFT) ? STALK_LEFT_LIGHT : STALK_RIGHT_LIGHT;
        interactive = ($urandom_range(0, 1) == 1);
        split       = ($urandom_range(0, 7) == 0);
        repeat ($urandom_range(0, 3)) begin
            queue_frame(($urandom_range(0, 2) == 0) ? light : STALK_NONE, ST_KEEPING,
                        DIR_NONE, 1'b0, interactive);
        end
        queue_frame(firm, ST_KEEPING, DIR_NONE, split, interactive);
        repeat ($urandom_range(0, 2)) begin
            queue_frame(STALK_NONE, ST_PROPOSE, dir, split, interactive);
        end
        repeat ($urandom_range(1, 6)) begin
            queue_frame(($urandom_range(0, 1) == 1) ? light : STALK_NONE, ST_EXECUTION, dir,
                        split, interactive);
        end
        if ($urandom_range(0, 2) != 0) begin
            if (dir == DIR_LEFT) begin
                opp = ($urandom_range(0, 1) == 1) ? STALK_RIGHT_FIRM : STALK_RIGHT_LIGHT;
            end else begin
                opp = ($urandom_range(0, 1) == 1) ? STALK_LEFT_FIRM : STALK_LEFT_LIGHT;
            end
            status  = STATUS_W'($urandom_range(1, 4));
            opp_req = ($urandom_range(0, 1) == 1) ? dir : DIR_NONE;
            queue_frame(opp, status, opp_req, split, interactive);
        end
        repeat ($urandom_range(0, 14)) begin
            queue_frame(STALK_NONE, ST_KEEPING, DIR_NONE, 1'b0, interactive);
        end
    endtask

    task automatic queue_random_frames(input int count);
        int          stop;
        logic [31:0] rnd;
        stop = frames_queued + count;
        while (frames_queued < stop) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_maneuver();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    rnd = $urandom;
                    queue_frame(rnd[2:0], rnd[5:3], rnd[7:6], rnd[8], rnd[9]);
                end
            end
        end
    endtask

    // driver: bursts of frames with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && item_if.ready) begin
                expected_frames.push_back(predict_frame(drv_item));
                frames_sent++;
            end
            if (!drv_valid || item_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end else if (pending_frames.size() != 0) begin
                    drv_item  <= pending_frames.pop_front();
                    drv_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transaction, stall on a changing pattern
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (result_if.valid && mon_ready) begin
                if (expected_frames.size() == 0) begin
                    report_error($sformatf("result with nothing pending: cmd %0d cancel %0d",
                                           result_if.latched_command, result_if.cancel_active));
                end else begin
                    want = expected_frames.pop_front();
                    if (result_if.latched_command !== want.latched_command) begin
                        report_error($sformatf("frame %0d latched_command: got %0d expected %0d",
                                               frames_checked, result_if.latched_command,
                                               want.latched_command));
                    end
                    if (result_if.cancel_active !== want.cancel_active) begin
                        report_error($sformatf("frame %0d cancel_active: got %0d expected %0d",
                                               frames_checked, result_if.cancel_active,
                                               want.cancel_active));
                    end
                end
                frames_checked++;
                if (result_if.latched_command != DIR_NONE) command_frames++;
                if (result_if.cancel_active) cancel_frames++;
            end
            if (ready_left <= 0) begin
                ready_mode = $urandom_range(0, 3);
                ready_left = $urandom_range(20, 80);
            end
            ready_left--;
            ready_phase++;
            case (ready_mode)
                0:       mon_ready <= 1'b1;
                1:       mon_ready <= ($urandom_range(0, 3) != 0);
                2:       mon_ready <= (ready_phase % 3 != 0);
                default: mon_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((drv_valid && item_if.ready) || (result_if.valid && mon_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("turn_stalk_lane_change_interpreter_tb: timeout, %0d results outstanding",
                 expected_frames.size());
        $display("turn_stalk_lane_change_interpreter_tb: errors");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: latch, re-latch block, cancels, lockout, spare codes
        queue_frame(STALK_NONE, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_LEFT_FIRM, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_LEFT_FIRM, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_NONE, ST_EXECUTION, DIR_LEFT, 1'b0, 1'b0);
        queue_frame(STALK_RIGHT_LIGHT, ST_EXECUTION, DIR_LEFT, 1'b0, 1'b0);
        queue_frame(STALK_RIGHT_FIRM, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_RIGHT_LIGHT, ST_HOLD, DIR_NONE, 1'b0, 1'b1);
        queue_frame(STALK_LEFT_FIRM, ST_CANCEL, DIR_RIGHT, 1'b0, 1'b1);
        queue_frame(STALK_SPARE_HI, ST_SPARE_HI, DIR_BAD, 1'b1, 1'b1);
        queue_frame(STALK_RIGHT_FIRM, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        wait_drained();

        // zero limits, preset above limit, ignored register index
        program_limits(8'd0, 8'd255, 8'd0);
        write_reg(CFG_SPARE, 8'hA5);
        queue_frame(STALK_NONE, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_LEFT_FIRM, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_NONE, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_RIGHT_FIRM, ST_KEEPING, DIR_NONE, 1'b1, 1'b1);
        queue_frame(STALK_SPARE_LO, ST_OTHER, DIR_BAD, 1'b0, 1'b0);
        queue_frame(STALK_RIGHT_FIRM, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_NONE, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_RIGHT_FIRM, ST_KEEPING, DIR_NONE, 1'b0, 1'b0);
        queue_frame(STALK_LEFT_LIGHT, ST_PROPOSE, DIR_BAD, 1'b0, 1'b0);
        queue_frame(STALK_SPARE_MID, ST_SPARE_MID, DIR_NONE, 1'b1, 1'b0);
        queue_frame(STALK_LEFT_FIRM, ST_OTHER, DIR_RIGHT, 1'b0, 1'b0);
        wait_drained();

        program_limits(RST_CANCEL_HOLD_LIMIT, RST_INTERACTIVE_HOLD_PRESET,
                       {4'h0, RST_RETRIGGER_LIMIT});
        queue_random_frames(PHASE_FRAMES);
        wait_drained();

        program_limits(8'd255, 8'd0, 8'hFF);
        queue_random_frames(PHASE_FRAMES);
        wait_drained();

        // lower both limits below the saturated counters
        program_limits(8'd1, 8'd0, 8'h01);
        queue_random_frames(PHASE_FRAMES);
        wait_drained();

        program_limits(8'd12, 8'd200, 8'h03);
        queue_random_frames(PHASE_FRAMES);
        wait_drained();

        repeat (2) begin
            program_limits(HOLD_W'($urandom_range(1, 255)), HOLD_W'($urandom),
                           CFG_DATA_W'($urandom));
            queue_random_frames(PHASE_FRAMES);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("turn_stalk_lane_change_interpreter_tb: %0d frames sent, %0d checked, %0d limit settings",
                 frames_sent, frames_checked, settings_used);
        $display("turn_stalk_lane_change_interpreter_tb: %0d frames with a command, %0d with cancel held",
                 command_frames, cancel_frames);
        if (error_count == 0) begin
            $display("turn_stalk_lane_change_interpreter_tb: clean");
        end else begin
            $display("turn_stalk_lane_change_interpreter_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
rtl/tsl_pkg.sv
rtl/tsl_in_if.sv
rtl/tsl_out_if.sv
rtl/tsl_step.sv
rtl/turn_stalk_lane_change_interpreter.sv
rtl/tsl_checker.sv
tb/turn_stalk_lane_change_interpreter_tb.sv
